// ----- src/serial_frame_link_engine_defines.svh -----
// Assertion helpers for the serial frame link engine checker.
`ifndef SERIAL_FRAME_LINK_ENGINE_DEFINES_SVH
`define SERIAL_FRAME_LINK_ENGINE_DEFINES_SVH

// Check a property at every clock edge once reset is released.
`define SFLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define SFLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/sfle_pkg.sv -----
package sfle_pkg;

  // Input transaction: start request or one received link byte
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [3:0] status;
    logic [7:0] data_byte;
    logic       last;
  } out_t;

  // Input function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_BYTE  = 1'b1;

  // Result status codes
  localparam logic [3:0] ST_SENDING    = 4'd0;
  localparam logic [3:0] ST_ACK_OK     = 4'd1;
  localparam logic [3:0] ST_ACK_BAD    = 4'd2;
  localparam logic [3:0] ST_HDR_BYTE   = 4'd3;
  localparam logic [3:0] ST_HDR_OK     = 4'd4;
  localparam logic [3:0] ST_HDR_BAD    = 4'd5;
  localparam logic [3:0] ST_PAYLOAD    = 4'd6;
  localparam logic [3:0] ST_FRAME_OK   = 4'd7;
  localparam logic [3:0] ST_FRAME_BAD  = 4'd8;

  // Link bytes
  localparam logic [7:0] ACK_BYTE  = 8'h80;
  localparam logic [7:0] NACK_BYTE = 8'h00;

  // Configuration register indexes
  localparam logic [1:0] REG_GROUP_ID     = 2'd0;
  localparam logic [1:0] REG_COMMAND_CODE = 2'd1;
  localparam logic [1:0] REG_REQUEST_SIZE = 2'd2;

endpackage

// ----- src/sfle_core.sv -----
module sfle_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  sfle_pkg::in_t item_i,
  output sfle_pkg::out_t res_o
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_WAIT_ACK = 3'd1;
  localparam logic [2:0] PH_HEADER   = 3'd2;
  localparam logic [2:0] PH_PAYLOAD  = 3'd3;
  localparam logic [2:0] PH_CHECKSUM = 3'd4;

  logic [2:0] phase_q, phase_d;
  logic [1:0] hdr_idx_q, hdr_idx_d;
  logic [7:0] tag_q, tag_d;
  logic [7:0] remain_q, remain_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] want;
  logic [7:0] remain_dec;

  assign want       = tag_q + remain_q;
  assign remain_dec = remain_q - 8'd1;

  // Compute next link state and the single result of a received byte
  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    tag_d     = tag_q;
    remain_d  = remain_q;
    sum_d     = sum_q;
    res_o.tx_valid  = 1'b0;
    res_o.tx_byte   = 8'h00;
    res_o.status    = sfle_pkg::ST_FRAME_BAD;
    res_o.data_byte = 8'h00;
    res_o.last      = 1'b1;
    if (item_i.func == sfle_pkg::FUNC_START) begin
      // Abort anything in flight and wait for the acknowledge
      phase_d   = PH_WAIT_ACK;
      hdr_idx_d = 2'd0;
      tag_d     = 8'h00;
      remain_d  = 8'h00;
      sum_d     = 8'h00;
    end else begin
      case (phase_q)
        PH_WAIT_ACK: begin
          if (item_i.rx_byte == sfle_pkg::ACK_BYTE) begin
            res_o.status = sfle_pkg::ST_ACK_OK;
            phase_d      = PH_HEADER;
            hdr_idx_d    = 2'd0;
          end else begin
            res_o.status = sfle_pkg::ST_ACK_BAD;
            phase_d      = PH_IDLE;
          end
        end
        PH_HEADER: begin
          if (hdr_idx_q == 2'd0) begin
            tag_d           = item_i.rx_byte;
            hdr_idx_d       = 2'd1;
            res_o.status    = sfle_pkg::ST_HDR_BYTE;
            res_o.data_byte = item_i.rx_byte;
          end else if (hdr_idx_q == 2'd1) begin
            remain_d        = item_i.rx_byte;
            hdr_idx_d       = 2'd2;
            res_o.status    = sfle_pkg::ST_HDR_BYTE;
            res_o.data_byte = item_i.rx_byte;
          end else begin
            // Check the reply header sum and answer ack or nack
            hdr_idx_d       = 2'd0;
            res_o.tx_valid  = 1'b1;
            res_o.data_byte = remain_q;
            if (want == item_i.rx_byte) begin
              res_o.tx_byte = sfle_pkg::ACK_BYTE;
              res_o.status  = sfle_pkg::ST_HDR_OK;
              sum_d         = 8'h00;
              phase_d       = (remain_q != 8'h00) ? PH_PAYLOAD : PH_CHECKSUM;
            end else begin
              res_o.tx_byte = sfle_pkg::NACK_BYTE;
              res_o.status  = sfle_pkg::ST_HDR_BAD;
              phase_d       = PH_IDLE;
            end
          end
        end
        PH_PAYLOAD: begin
          sum_d           = sum_q + item_i.rx_byte;
          remain_d        = remain_dec;
          res_o.status    = sfle_pkg::ST_PAYLOAD;
          res_o.data_byte = item_i.rx_byte;
          if (remain_dec == 8'h00) begin
            phase_d = PH_CHECKSUM;
          end
        end
        PH_CHECKSUM: begin
          res_o.status = (item_i.rx_byte == sum_q) ? sfle_pkg::ST_FRAME_OK
                                                   : sfle_pkg::ST_FRAME_BAD;
          phase_d      = PH_IDLE;
        end
        default: begin
          // Idle or unused code: drop the byte and report a bad frame
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Advance state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      hdr_idx_q <= 2'd0;
      tag_q     <= 8'h00;
      remain_q  <= 8'h00;
      sum_q     <= 8'h00;
    end else if (acc_i) begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      tag_q     <= tag_d;
      remain_q  <= remain_d;
      sum_q     <= sum_d;
    end
  end

endmodule

// ----- src/serial_frame_link_engine.sv -----
// Host-side engine for a byte link with length-prefixed, checksummed frames.
// Input channel (in_valid_i / in_stall_o / in_data_i): a start transaction
// (func 0) or one byte received from the link (func 1). Output channel
// (out_valid_o / out_stall_i / out_data_o): results, with last set on the
// final result belonging to one input transaction.
// Configuration: write group_id, command_code and request_size through
// cfg_we_i / cfg_idx_i / cfg_data_i while the engine is idle.
// The first result of a transaction is shown the cycle after it is
// accepted. A received byte gives one result, so bytes can be accepted every
// cycle while the receiver does not stall. A start gives four header bytes
// from the result buffer; the output channel carries one result per cycle
// unless stalled, so the next transaction waits until the last one leaves.
// A new transaction is taken in the same cycle the last pending result
// leaves. When the receiver stalls, the current result holds and the input
// stalls once the buffer is full.
// Reset clears the link state to idle, empties the result buffer and loads
// the registers with group 1, command 1, size 0.
module serial_frame_link_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sfle_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sfle_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [7:0]     cfg_data_i
);

  logic [7:0] group_q, command_q, size_q;
  logic       busy_q;
  logic       start_q;
  logic [1:0] ptr_q;
  logic [7:0] hdr_q [4];
  sfle_pkg::out_t res_q;
  sfle_pkg::out_t core_res;
  logic       in_acc;
  logic       out_acc;
  logic       out_last;
  logic [7:0] hdr_sum;

  assign hdr_sum  = group_q + command_q + size_q;
  assign out_last = out_data_o.last;
  assign out_acc  = busy_q && !out_stall_i;
  assign in_stall_o = busy_q && !(out_acc && out_last);
  assign in_acc   = in_valid_i && !in_stall_o;

  sfle_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (in_acc),
    .item_i (in_data_i),
    .res_o  (core_res)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q   <= 8'd1;
      command_q <= 8'd1;
      size_q    <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfle_pkg::REG_GROUP_ID:     group_q   <= cfg_data_i;
        sfle_pkg::REG_COMMAND_CODE: command_q <= cfg_data_i;
        sfle_pkg::REG_REQUEST_SIZE: size_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Result buffer control: load on accept, step through header bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      start_q <= 1'b0;
      ptr_q   <= 2'd0;
    end else if (in_acc) begin
      busy_q  <= 1'b1;
      start_q <= (in_data_i.func == sfle_pkg::FUNC_START);
      ptr_q   <= 2'd0;
    end else if (out_acc) begin
      if (out_last) begin
        busy_q <= 1'b0;
      end else begin
        ptr_q <= ptr_q + 2'd1;
      end
    end
  end

  // Result buffer payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q    <= core_res;
      hdr_q[0] <= group_q;
      hdr_q[1] <= command_q;
      hdr_q[2] <= size_q;
      hdr_q[3] <= hdr_sum;
    end
  end

  // Present the pending result
  always_comb begin
    out_valid_o = busy_q;
    if (start_q) begin
      out_data_o.tx_valid  = 1'b1;
      out_data_o.tx_byte   = hdr_q[ptr_q];
      out_data_o.status    = sfle_pkg::ST_SENDING;
      out_data_o.data_byte = 8'h00;
      out_data_o.last      = (ptr_q == 2'd3);
    end else begin
      out_data_o = res_q;
    end
  end

endmodule

// ----- src/sfle_checker.sv -----
`include "serial_frame_link_engine_defines.svh"

module sfle_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input sfle_pkg::out_t out_data_o
);

  // Hold a stalled result
  `SFLE_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  // Show a result the cycle after an accepted transaction
  `SFLE_ASSERT(a_in_to_out, in_valid_i && !in_stall_o |=> out_valid_o, "no result after accept")

  // Header and ack/nack results must transmit
  `SFLE_ASSERT(a_tx_status, out_valid_o && !out_data_o.tx_valid |-> out_data_o.status != sfle_pkg::ST_SENDING && out_data_o.status != sfle_pkg::ST_HDR_OK && out_data_o.status != sfle_pkg::ST_HDR_BAD, "status needs tx")

  // Keep the output channel empty after reset is seen low
  `SFLE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result after reset")

endmodule

bind serial_frame_link_engine sfle_checker u_sfle_checker (.*);

// ----- tb/tb_serial_frame_link_engine.sv -----
`timescale 1ns / 1ps

module tb_serial_frame_link_engine;

  // Link state as the engine tracks it
  typedef enum logic [2:0] {
    LINK_IDLE,
    LINK_WAIT_ACK,
    LINK_HEADER,
    LINK_PAYLOAD,
    LINK_CHECKSUM
  } link_phase_e;

  // One input transaction with an optional hold until all results are back
  typedef struct {
    sfle_pkg::in_t data;
    bit            drain;
  } link_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  sfle_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  sfle_pkg::out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [7:0] cfg_data_i = '0;

  serial_frame_link_engine u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Register shadows and link state of the predictor
  logic [7:0]  group_reg = 8'd1;
  logic [7:0]  command_reg = 8'd1;
  logic [7:0]  size_reg = 8'd0;
  link_phase_e link_phase = LINK_IDLE;
  logic [1:0]  hdr_idx = '0;
  logic [7:0]  reply_tag = '0;
  logic [7:0]  bytes_left = '0;
  logic [7:0]  payload_sum = '0;

  link_item_t     link_items[$];
  sfle_pkg::out_t awaited_results[$];
  int         queued_items = 0;
  int         fail_count = 0;
  int         send_gap = 0;
  int         hold_cycles = 0;
  bit         steady_flow = 1'b0;
  bit         drv_presenting;

  function automatic sfle_pkg::out_t link_result(logic txv, logic [7:0] txb,
                                                 logic [3:0] st, logic [7:0] db,
                                                 logic lst);
    sfle_pkg::out_t r;
    r.tx_valid  = txv;
    r.tx_byte   = txb;
    r.status    = st;
    r.data_byte = db;
    r.last      = lst;
    return r;
  endfunction

  // Advance the link state by one accepted transaction and queue its results
  function automatic void predict_link(sfle_pkg::in_t item);
    logic [7:0] hdr_sum;
    if (item.func == sfle_pkg::FUNC_START) begin
      hdr_sum = group_reg + command_reg + size_reg;
      awaited_results.push_back(
        link_result(1'b1, group_reg, sfle_pkg::ST_SENDING, 8'd0, 1'b0));
      awaited_results.push_back(
        link_result(1'b1, command_reg, sfle_pkg::ST_SENDING, 8'd0, 1'b0));
      awaited_results.push_back(
        link_result(1'b1, size_reg, sfle_pkg::ST_SENDING, 8'd0, 1'b0));
      awaited_results.push_back(
        link_result(1'b1, hdr_sum, sfle_pkg::ST_SENDING, 8'd0, 1'b1));
      link_phase  = LINK_WAIT_ACK;
      hdr_idx     = '0;
      reply_tag   = '0;
      bytes_left  = '0;
      payload_sum = '0;
    end else begin
      case (link_phase)
        LINK_WAIT_ACK: begin
          if (item.rx_byte == sfle_pkg::ACK_BYTE) begin
            awaited_results.push_back(
              link_result(1'b0, 8'd0, sfle_pkg::ST_ACK_OK, 8'd0, 1'b1));
            link_phase = LINK_HEADER;
            hdr_idx    = '0;
          end else begin
            awaited_results.push_back(
              link_result(1'b0, 8'd0, sfle_pkg::ST_ACK_BAD, 8'd0, 1'b1));
            link_phase = LINK_IDLE;
          end
        end
        LINK_HEADER: begin
          if (hdr_idx == 2'd0) begin
            reply_tag = item.rx_byte;
            hdr_idx   = 2'd1;
            awaited_results.push_back(
              link_result(1'b0, 8'd0, sfle_pkg::ST_HDR_BYTE, item.rx_byte, 1'b1));
          end else if (hdr_idx == 2'd1) begin
            bytes_left = item.rx_byte;
            hdr_idx    = 2'd2;
            awaited_results.push_back(
              link_result(1'b0, 8'd0, sfle_pkg::ST_HDR_BYTE, item.rx_byte, 1'b1));
          end else begin
            hdr_sum = reply_tag + bytes_left;
            hdr_idx = '0;
            if (hdr_sum == item.rx_byte) begin
              awaited_results.push_back(link_result(1'b1, sfle_pkg::ACK_BYTE,
                sfle_pkg::ST_HDR_OK, bytes_left, 1'b1));
              payload_sum = '0;
              link_phase  = (bytes_left != 8'd0) ? LINK_PAYLOAD : LINK_CHECKSUM;
            end else begin
              awaited_results.push_back(link_result(1'b1, sfle_pkg::NACK_BYTE,
                sfle_pkg::ST_HDR_BAD, bytes_left, 1'b1));
              link_phase = LINK_IDLE;
            end
          end
        end
        LINK_PAYLOAD: begin
          payload_sum = payload_sum + item.rx_byte;
          bytes_left  = bytes_left - 8'd1;
          if (bytes_left == 8'd0) link_phase = LINK_CHECKSUM;
          awaited_results.push_back(
            link_result(1'b0, 8'd0, sfle_pkg::ST_PAYLOAD, item.rx_byte, 1'b1));
        end
        LINK_CHECKSUM: begin
          awaited_results.push_back(link_result(1'b0, 8'd0,
            (item.rx_byte == payload_sum) ? sfle_pkg::ST_FRAME_OK
                                          : sfle_pkg::ST_FRAME_BAD,
            8'd0, 1'b1));
          link_phase = LINK_IDLE;
        end
        default: begin
          link_phase = LINK_IDLE;
          awaited_results.push_back(
            link_result(1'b0, 8'd0, sfle_pkg::ST_FRAME_BAD, 8'd0, 1'b1));
        end
      endcase
    end
  endfunction

  // Wait cycles before the next transaction on either side
  function automatic int draw_wait();
    if (steady_flow) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic void check_field(string name, logic [7:0] expected, logic [7:0] actual);
    if (expected !== actual) begin
      $error("%s expected %0d actual %0d", name, expected, actual);
      fail_count++;
    end
  endfunction

  function automatic void compare_result(sfle_pkg::out_t got);
    sfle_pkg::out_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result: status %0d tx_byte %0d", got.status, got.tx_byte);
      fail_count++;
    end else begin
      want = awaited_results.pop_front();
      check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      check_field("tx_byte", want.tx_byte, got.tx_byte);
      check_field("status", 8'(want.status), 8'(got.status));
      check_field("data_byte", want.data_byte, got.data_byte);
      check_field("last", 8'(want.last), 8'(got.last));
    end
  endfunction

  // Driver: present queued transactions, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap = 0;
    end else begin
      drv_presenting = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        predict_link(in_data_i);
        drv_presenting = 1'b0;
      end
      if (!drv_presenting && link_items.size() != 0) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (!link_items[0].drain || awaited_results.size() == 0) begin
          in_data_i <= link_items[0].data;
          link_items.delete(0);
          drv_presenting = 1'b1;
          send_gap = draw_wait();
        end
      end
      in_valid_i <= drv_presenting;
    end
  end

  // Monitor: check accepted results and stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        compare_result(out_data_o);
        hold_cycles = draw_wait();
      end else if (hold_cycles != 0) begin
        hold_cycles--;
      end
      out_stall_i <= (hold_cycles != 0);
    end
  end

  task automatic queue_item(logic func, logic [7:0] rx, bit drain);
    link_item_t it;
    it.data.func    = func;
    it.data.rx_byte = rx;
    it.drain        = drain;
    link_items.push_back(it);
    queued_items++;
  endtask

  // Queue one exchange; stop early on a bad ack, a bad header or an abort
  task automatic queue_frame(logic [7:0] ack, bit hdr_good, logic [7:0] tag,
                             logic [7:0] len, int abort_after, bit csum_good, bit drain);
    logic [7:0] hdr_sum;
    logic [7:0] pay_sum;
    logic [7:0] b;
    queue_item(sfle_pkg::FUNC_START, 8'($urandom_range(0, 255)), drain);
    queue_item(sfle_pkg::FUNC_BYTE, ack, 1'b0);
    if (ack != sfle_pkg::ACK_BYTE) return;
    hdr_sum = tag + len;
    if (!hdr_good) hdr_sum = hdr_sum + 8'($urandom_range(1, 255));
    queue_item(sfle_pkg::FUNC_BYTE, tag, 1'b0);
    queue_item(sfle_pkg::FUNC_BYTE, len, 1'b0);
    queue_item(sfle_pkg::FUNC_BYTE, hdr_sum, 1'b0);
    if (!hdr_good) return;
    pay_sum = '0;
    for (int i = 0; i < int'(len); i++) begin
      if (i == abort_after) return;
      b = 8'($urandom_range(0, 255));
      pay_sum = pay_sum + b;
      queue_item(sfle_pkg::FUNC_BYTE, b, 1'b0);
    end
    if (!csum_good) pay_sum = pay_sum + 8'($urandom_range(1, 255));
    queue_item(sfle_pkg::FUNC_BYTE, pay_sum, 1'b0);
  endtask

  // Mostly well-formed exchanges with random content, some noise
  task automatic queue_random_frame();
    int         pick;
    int         abort_at;
    logic [7:0] ack;
    logic [7:0] len;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      queue_item(sfle_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)), 1'b0);
    end else if (pick == 1) begin
      queue_item(sfle_pkg::FUNC_START, 8'($urandom_range(0, 255)), 1'b0);
    end else begin
      ack = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : sfle_pkg::ACK_BYTE;
      if ($urandom_range(0, 5) == 0) len = 8'd0;
      else if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(9, 24));
      else len = 8'($urandom_range(1, 8));
      abort_at = -1;
      if (len != 8'd0 && $urandom_range(0, 9) == 0) abort_at = $urandom_range(0, int'(len) - 1);
      queue_frame(ack, $urandom_range(0, 7) != 0, 8'($urandom_range(0, 255)), len,
                  abort_at, $urandom_range(0, 9) < 7, $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      sfle_pkg::REG_GROUP_ID:     group_reg = val;
      sfle_pkg::REG_COMMAND_CODE: command_reg = val;
      sfle_pkg::REG_REQUEST_SIZE: size_reg = val;
      default: ;
    endcase
  endtask

  // Hold until every transaction is sent and every result has come back
  task automatic wait_link_quiet();
    do @(negedge clk_i);
    while (link_items.size() != 0 || in_valid_i || awaited_results.size() != 0);
  endtask

  initial begin
    int target;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 4; p++) begin
      if (p != 0) begin
        wait_link_quiet();
        steady_flow = (p == 1);
        case (p)
          1: begin
            write_reg(sfle_pkg::REG_GROUP_ID, 8'hFF);
            write_reg(sfle_pkg::REG_COMMAND_CODE, 8'hFF);
            write_reg(sfle_pkg::REG_REQUEST_SIZE, 8'hFF);
          end
          2: begin
            write_reg(sfle_pkg::REG_GROUP_ID, 8'h00);
            write_reg(sfle_pkg::REG_COMMAND_CODE, 8'h00);
            write_reg(sfle_pkg::REG_REQUEST_SIZE, 8'h00);
          end
          default: begin
            write_reg(sfle_pkg::REG_GROUP_ID, 8'($urandom_range(0, 255)));
            write_reg(sfle_pkg::REG_COMMAND_CODE, 8'($urandom_range(0, 255)));
            write_reg(sfle_pkg::REG_REQUEST_SIZE, 8'($urandom_range(0, 255)));
          end
        endcase
      end
      @(negedge clk_i);
      if (p == 0) begin
        // byte while idle, bad ack, byte while idle again
        queue_item(sfle_pkg::FUNC_BYTE, 8'hFF, 1'b0);
        queue_frame(8'h7F, 1'b1, 8'h00, 8'h00, -1, 1'b1, 1'b0);
        queue_item(sfle_pkg::FUNC_BYTE, 8'h00, 1'b0);
        // zero length with tag at max, sent once the link is drained
        queue_frame(sfle_pkg::ACK_BYTE, 1'b1, 8'hFF, 8'h00, -1, 1'b1, 1'b1);
        // bad reply header
        queue_frame(sfle_pkg::ACK_BYTE, 1'b0, 8'h10, 8'h02, -1, 1'b1, 1'b0);
        // max length with wrapping header sum, aborted by the next start
        queue_frame(sfle_pkg::ACK_BYTE, 1'b1, 8'h01, 8'hFF, 2, 1'b1, 1'b0);
        // bad trailing checksum
        queue_frame(sfle_pkg::ACK_BYTE, 1'b1, 8'h00, 8'h01, -1, 1'b0, 1'b0);
      end
      target = queued_items + 30;
      while (queued_items < target) queue_random_frame();
    end

    wait_link_quiet();
    repeat (10) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
